// File: src/shape_pair_overlap_test_assert.svh
// assertion macros shared by the shape pair overlap test rtl
`ifndef SHAPE_PAIR_OVERLAP_TEST_ASSERT_SVH
`define SHAPE_PAIR_OVERLAP_TEST_ASSERT_SVH

// same-cycle implication, checked outside reset
`define SPOT_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("spot assertion failed");

// next-cycle implication, checked outside reset
`define SPOT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("spot assertion failed");

`endif

// File: src/spot_pkg.sv
// types, widths and codes for the shape pair overlap test
package spot_pkg;

  // coordinate width, sizes are one bit narrower
  localparam int COORD_BITS = 16;
  localparam int SIZE_BITS  = COORD_BITS - 1;
  // radius or radius sum
  localparam int RAD_BITS   = COORD_BITS;
  // rect-rect compare width
  localparam int RR_BITS    = COORD_BITS + 1;
  // doubled-unit signed offset
  localparam int DIFF_BITS  = COORD_BITS + 3;
  // offset magnitude and limits
  localparam int MAG_BITS   = COORD_BITS + 2;
  // doubled radius and corner excess
  localparam int EXT_BITS   = COORD_BITS + 1;
  localparam int SQ_BITS    = 2 * EXT_BITS;
  localparam int NUM_STAGES = 5;

  typedef enum logic [1:0] {
    KIND_CIRCLE = 2'd0,
    KIND_RECT   = 2'd1,
    KIND_LINE   = 2'd2
  } shape_kind_e;

  typedef enum logic [1:0] {
    PAIR_CC   = 2'd0,
    PAIR_CR   = 2'd1,
    PAIR_RR   = 2'd2,
    PAIR_NONE = 2'd3
  } pair_kind_e;

  typedef struct packed {
    logic [1:0]                   a_kind;
    logic signed [COORD_BITS-1:0] a_x;
    logic signed [COORD_BITS-1:0] a_y;
    logic [SIZE_BITS-1:0]         a_w;
    logic [SIZE_BITS-1:0]         a_h;
    logic [1:0]                   b_kind;
    logic signed [COORD_BITS-1:0] b_x;
    logic signed [COORD_BITS-1:0] b_y;
    logic [SIZE_BITS-1:0]         b_w;
    logic [SIZE_BITS-1:0]         b_h;
  } spot_in_t;

  typedef struct packed {
    logic       hit;
    pair_kind_e pair_kind;
  } spot_out_t;

endpackage

// File: src/shape_pair_overlap_test.sv
// shape pair overlap test: five-stage pipeline, circle and rectangle pairs
//
//   channel | signals                          | moves
//   --------+----------------------------------+-------------------------
//   in      | in_valid_i in_ready_o in_data_i  | one shape pair per transfer
//   out     | out_valid_o out_ready_i out_data_o | hit flag and pair kind
//
// one pair per cycle while the output is not stalled: five register stages (offset, magnitude,
// compare, square, sum and compare), none of which is shared between items
// no state besides the pipeline: reset only empties the valid bits
// a stall at the output holds each full stage; empty stages still fill, so the
// input keeps taking transfers until every stage holds an item
`include "shape_pair_overlap_test_assert.svh"

module shape_pair_overlap_test (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  spot_pkg::spot_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output spot_pkg::spot_out_t out_data_o
);
  import spot_pkg::*;

  // stage valid bits and load enables
  logic [NUM_STAGES-1:0] vld_q;
  logic [NUM_STAGES-1:0] en;

  always_comb begin
    en[NUM_STAGES-1] = !vld_q[NUM_STAGES-1] || out_ready_i;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = vld_q[NUM_STAGES-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) begin
        vld_q[0] <= in_valid_i;
      end
      for (int k = 1; k < NUM_STAGES; k++) begin
        if (en[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stage 1: pair decode, operand select, doubled centre offsets, rect-rect test
  // ---------------------------------------------------------------------------
  pair_kind_e                  pk;
  logic                        b_is_circ;
  logic signed [COORD_BITS-1:0] cx, cy, rx, ry;
  logic [RAD_BITS-1:0]         rad;
  logic [SIZE_BITS-1:0]        rw, rh;
  logic signed [DIFF_BITS-1:0] dx_d, dy_d;
  logic signed [RR_BITS-1:0]   ax_e, ay_e, bx_e, by_e;
  logic signed [RR_BITS-1:0]   aw_e, ah_e, bw_e, bh_e;
  logic                        rr_hit_d;

  always_comb begin
    if (in_data_i.a_kind == KIND_CIRCLE && in_data_i.b_kind == KIND_CIRCLE) begin
      pk = PAIR_CC;
    end else if (in_data_i.a_kind == KIND_CIRCLE && in_data_i.b_kind == KIND_RECT) begin
      pk = PAIR_CR;
    end else if (in_data_i.a_kind == KIND_RECT && in_data_i.b_kind == KIND_CIRCLE) begin
      pk = PAIR_CR;
    end else if (in_data_i.a_kind == KIND_RECT && in_data_i.b_kind == KIND_RECT) begin
      pk = PAIR_RR;
    end else begin
      pk = PAIR_NONE;
    end
    b_is_circ = (in_data_i.a_kind == KIND_RECT);

    // circle-circle is a point rectangle at b against radius sum
    if (pk == PAIR_CC) begin
      cx  = in_data_i.a_x;
      cy  = in_data_i.a_y;
      rx  = in_data_i.b_x;
      ry  = in_data_i.b_y;
      rad = RAD_BITS'(in_data_i.a_w) + RAD_BITS'(in_data_i.b_w);
      rw  = '0;
      rh  = '0;
    end else if (b_is_circ) begin
      cx  = in_data_i.b_x;
      cy  = in_data_i.b_y;
      rx  = in_data_i.a_x;
      ry  = in_data_i.a_y;
      rad = RAD_BITS'(in_data_i.b_w);
      rw  = in_data_i.a_w;
      rh  = in_data_i.a_h;
    end else begin
      cx  = in_data_i.a_x;
      cy  = in_data_i.a_y;
      rx  = in_data_i.b_x;
      ry  = in_data_i.b_y;
      rad = RAD_BITS'(in_data_i.a_w);
      rw  = in_data_i.b_w;
      rh  = in_data_i.b_h;
    end

    // doubled units keep the rectangle centre exact
    dx_d = (DIFF_BITS'(cx) <<< 1) - (DIFF_BITS'(rx) <<< 1)
           - $signed(DIFF_BITS'(rw));
    dy_d = (DIFF_BITS'(cy) <<< 1) - (DIFF_BITS'(ry) <<< 1)
           - $signed(DIFF_BITS'(rh));

    // inclusive interval overlap on both axes
    ax_e = RR_BITS'(in_data_i.a_x);
    ay_e = RR_BITS'(in_data_i.a_y);
    bx_e = RR_BITS'(in_data_i.b_x);
    by_e = RR_BITS'(in_data_i.b_y);
    aw_e = $signed(RR_BITS'(in_data_i.a_w));
    ah_e = $signed(RR_BITS'(in_data_i.a_h));
    bw_e = $signed(RR_BITS'(in_data_i.b_w));
    bh_e = $signed(RR_BITS'(in_data_i.b_h));
    rr_hit_d = (ax_e <= bx_e + bw_e) && (ax_e + aw_e >= bx_e) &&
               (ay_e <= by_e + bh_e) && (ay_e + ah_e >= by_e);
  end

  pair_kind_e                  s1_pk_q;
  logic                        s1_rr_q;
  logic signed [DIFF_BITS-1:0] s1_dx_q, s1_dy_q;
  logic [EXT_BITS-1:0]         s1_r2_q;
  logic [SIZE_BITS-1:0]        s1_w_q, s1_h_q;

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      s1_pk_q <= pk;
      s1_rr_q <= rr_hit_d;
      s1_dx_q <= dx_d;
      s1_dy_q <= dy_d;
      s1_r2_q <= {rad, 1'b0};
      s1_w_q  <= rw;
      s1_h_q  <= rh;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 2: offset magnitudes and outer limits
  // ---------------------------------------------------------------------------
  logic [DIFF_BITS-1:0] neg_dx, neg_dy;
  logic [MAG_BITS-1:0]  mag_x_d, mag_y_d, lim_x_d, lim_y_d;

  always_comb begin
    neg_dx  = -s1_dx_q;
    neg_dy  = -s1_dy_q;
    mag_x_d = s1_dx_q[DIFF_BITS-1] ? neg_dx[MAG_BITS-1:0] : s1_dx_q[MAG_BITS-1:0];
    mag_y_d = s1_dy_q[DIFF_BITS-1] ? neg_dy[MAG_BITS-1:0] : s1_dy_q[MAG_BITS-1:0];
    lim_x_d = MAG_BITS'(s1_w_q) + MAG_BITS'(s1_r2_q);
    lim_y_d = MAG_BITS'(s1_h_q) + MAG_BITS'(s1_r2_q);
  end

  pair_kind_e           s2_pk_q;
  logic                 s2_rr_q;
  logic [MAG_BITS-1:0]  s2_mx_q, s2_my_q, s2_lx_q, s2_ly_q;
  logic [EXT_BITS-1:0]  s2_r2_q;
  logic [SIZE_BITS-1:0] s2_w_q, s2_h_q;

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      s2_pk_q <= s1_pk_q;
      s2_rr_q <= s1_rr_q;
      s2_mx_q <= mag_x_d;
      s2_my_q <= mag_y_d;
      s2_lx_q <= lim_x_d;
      s2_ly_q <= lim_y_d;
      s2_r2_q <= s1_r2_q;
      s2_w_q  <= s1_w_q;
      s2_h_q  <= s1_h_q;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 3: region compares and corner excess
  // ---------------------------------------------------------------------------
  logic                out_any, in_any;
  logic [MAG_BITS-1:0] ex_full, ey_full;

  always_comb begin
    out_any = (s2_mx_q > s2_lx_q) || (s2_my_q > s2_ly_q);
    in_any  = (s2_mx_q <= MAG_BITS'(s2_w_q)) || (s2_my_q <= MAG_BITS'(s2_h_q));
    // only used in the corner region, where it is at most the doubled radius
    ex_full = s2_mx_q - MAG_BITS'(s2_w_q);
    ey_full = s2_my_q - MAG_BITS'(s2_h_q);
  end

  pair_kind_e          s3_pk_q;
  logic                s3_rr_q;
  logic                s3_known_q, s3_val_q;
  logic [EXT_BITS-1:0] s3_ex_q, s3_ey_q, s3_r2_q;

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      s3_pk_q    <= s2_pk_q;
      s3_rr_q    <= s2_rr_q;
      s3_known_q <= out_any || in_any;
      s3_val_q   <= !out_any;
      s3_ex_q    <= ex_full[EXT_BITS-1:0];
      s3_ey_q    <= ey_full[EXT_BITS-1:0];
      s3_r2_q    <= s2_r2_q;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 4: squares
  // ---------------------------------------------------------------------------
  pair_kind_e         s4_pk_q;
  logic               s4_rr_q;
  logic               s4_known_q, s4_val_q;
  logic [SQ_BITS-1:0] s4_ex2_q, s4_ey2_q, s4_r2sq_q;

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      s4_pk_q    <= s3_pk_q;
      s4_rr_q    <= s3_rr_q;
      s4_known_q <= s3_known_q;
      s4_val_q   <= s3_val_q;
      s4_ex2_q   <= SQ_BITS'(s3_ex_q) * SQ_BITS'(s3_ex_q);
      s4_ey2_q   <= SQ_BITS'(s3_ey_q) * SQ_BITS'(s3_ey_q);
      s4_r2sq_q  <= SQ_BITS'(s3_r2_q) * SQ_BITS'(s3_r2_q);
    end
  end

  // ---------------------------------------------------------------------------
  // stage 5: corner distance compare and result select into output register
  // ---------------------------------------------------------------------------
  logic      corner_hit;
  spot_out_t res_d;

  always_comb begin
    corner_hit = ((SQ_BITS + 1)'(s4_ex2_q) + (SQ_BITS + 1)'(s4_ey2_q))
                 <= (SQ_BITS + 1)'(s4_r2sq_q);
    res_d.pair_kind = s4_pk_q;
    case (s4_pk_q)
      PAIR_CC, PAIR_CR: res_d.hit = s4_known_q ? s4_val_q : corner_hit;
      PAIR_RR:          res_d.hit = s4_rr_q;
      default:          res_d.hit = 1'b0;
    endcase
  end

  spot_out_t out_q;

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      out_q <= res_d;
    end
  end

  assign out_data_o = out_q;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  `SPOT_ASSERT_NOW(a_none_no_hit, out_valid_o && out_data_o.pair_kind == PAIR_NONE,
                   !out_data_o.hit)
  `SPOT_ASSERT_NOW(a_full_when_blocked, !in_ready_o, (&vld_q) && !out_ready_i)
  `SPOT_ASSERT_NEXT(a_mid_stall_holds, vld_q[2] && !en[2],
                    vld_q[2] && $stable(s3_ex_q) && $stable(s3_known_q))

endmodule
